/* src/gatq_pkg.sv */
// ----------------------------------------------------------------------------
// gatq_pkg: glyph atlas packer and text quads, shared definitions
// Types, codes, reset values and saturation helpers used by the unit.
// ----------------------------------------------------------------------------
package gatq_pkg;

	localparam int GLYPH_TABLE_DEPTH = 128;
	localparam int QUEUE_DEPTH       = 2;
	localparam int NUM_VERTS         = 6;

	localparam logic [12:0] MAX_ROW_WIDTH_RST = 13'd1024;
	localparam logic [9:0]  LINE_HEIGHT_RST   = 10'd16;
	localparam logic [9:0]  FONT_SIZE_RST     = 10'd16;

	localparam logic [7:0]  CODE_NEWLINE = 8'd10;

	localparam logic [12:0] U_MAX = 13'h1FFF;
	localparam logic [14:0] V_MAX = 15'h7FFF;

	// vertex order (L,T) (R,T) (L,B) (R,T) (L,B) (R,B)
	localparam logic [NUM_VERTS-1:0] VTX_RIGHT  = 6'b101010;
	localparam logic [NUM_VERTS-1:0] VTX_BOTTOM = 6'b110100;
	localparam logic [2:0]           VTX_LAST   = 3'(NUM_VERTS - 1);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_BEGIN  = 2'd2,
		ACT_RENDER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_MAX_ROW_WIDTH = 2'd0,
		REG_LINE_HEIGHT   = 2'd1,
		REG_FONT_SIZE     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_BEGIN,
		OP_NEWLINE,
		OP_GLYPH
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STATUS,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t               op;
		logic              store;
		logic [7:0]        code;
		logic [7:0]        bw;
		logic [7:0]        bh;
		logic signed [8:0] bl;
		logic signed [8:0] bt;
		logic signed [9:0] ax;
		logic signed [9:0] ay;
	} item_t;

	typedef struct packed {
		logic signed [9:0] ax;
		logic signed [9:0] ay;
		logic [7:0]        bw;
		logic [7:0]        bh;
		logic signed [8:0] bl;
		logic signed [8:0] bt;
		logic [12:0]       u;
		logic [14:0]       v;
	} glyph_t;

	typedef struct packed {
		logic               is_vertex;
		logic               last;
		logic signed [19:0] vertex_x;
		logic signed [19:0] vertex_y;
		logic [12:0]        tex_u;
		logic [14:0]        tex_v;
		logic [12:0]        used_width;
		logic [14:0]        used_height;
	} res_t;

	function automatic logic signed [19:0] sat_pos(input logic signed [21:0] val);
		if (val > 22'sd524287) begin
			return 20'sh7FFFF;
		end else if (val < -22'sd524288) begin
			return 20'sh80000;
		end
		return val[19:0];
	endfunction

	function automatic logic [12:0] sat_u(input logic [13:0] val);
		return val[13] ? U_MAX : val[12:0];
	endfunction

	function automatic logic [14:0] sat_v(input logic [15:0] val);
		return val[15] ? V_MAX : val[14:0];
	endfunction

endpackage

/* src/gatq_in_if.sv */
// ----------------------------------------------------------------------------
// gatq_in_if: input item channel
// Valid/ready channel carrying one atlas clear, glyph load or text item.
// ----------------------------------------------------------------------------
interface gatq_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [7:0]         char_code;
	logic [7:0]         glyph_width;
	logic [7:0]         glyph_rows;
	logic signed [8:0]  bearing_left;
	logic signed [8:0]  bearing_top;
	logic signed [15:0] advance_x_raw;
	logic signed [15:0] advance_y_raw;

	modport source(
		output valid, action, char_code, glyph_width, glyph_rows,
		output bearing_left, bearing_top, advance_x_raw, advance_y_raw,
		input  ready
	);
	modport sink(
		input  valid, action, char_code, glyph_width, glyph_rows,
		input  bearing_left, bearing_top, advance_x_raw, advance_y_raw,
		output ready
	);
endinterface

/* src/gatq_out_if.sv */
// ----------------------------------------------------------------------------
// gatq_out_if: result item channel
// Valid/ready channel carrying vertex and atlas status items.
// ----------------------------------------------------------------------------
interface gatq_out_if;
	logic               valid;
	logic               ready;
	logic               is_vertex;
	logic               last;
	logic signed [19:0] vertex_x;
	logic signed [19:0] vertex_y;
	logic [12:0]        tex_u;
	logic [14:0]        tex_v;
	logic [12:0]        used_width;
	logic [14:0]        used_height;

	modport source(
		output valid, is_vertex, last, vertex_x, vertex_y,
		output tex_u, tex_v, used_width, used_height,
		input  ready
	);
	modport sink(
		input  valid, is_vertex, last, vertex_x, vertex_y,
		input  tex_u, tex_v, used_width, used_height,
		output ready
	);
endinterface

/* src/gatq_cfg_if.sv */
// ----------------------------------------------------------------------------
// gatq_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface gatq_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/gatq_front.sv */
// ----------------------------------------------------------------------------
// gatq_front: item intake and classification
// Decodes each accepted item into an operation and drops renders that
// cannot produce anything or change any state.
// ----------------------------------------------------------------------------
module gatq_front #(
	parameter int TABLE_DEPTH = gatq_pkg::GLYPH_TABLE_DEPTH
) (
	gatq_in_if.sink          req,
	input  logic             full,
	output logic             push,
	output gatq_pkg::item_t  push_item
);

	logic in_table;
	logic keep;

	assign in_table  = {1'b0, req.char_code} < 9'(TABLE_DEPTH);
	assign req.ready = !full;
	assign push      = req.valid && !full && keep;

	always_comb begin
		push_item       = '0;
		push_item.store = in_table;
		push_item.code  = req.char_code;
		push_item.bw    = req.glyph_width;
		push_item.bh    = req.glyph_rows;
		push_item.bl    = req.bearing_left;
		push_item.bt    = req.bearing_top;
		push_item.ax    = req.advance_x_raw[15:6];
		push_item.ay    = req.advance_y_raw[15:6];
		keep            = 1'b1;
		unique case (gatq_pkg::action_t'(req.action))
			gatq_pkg::ACT_CLEAR: begin
				push_item.op = gatq_pkg::OP_CLEAR;
			end
			gatq_pkg::ACT_LOAD: begin
				push_item.op = gatq_pkg::OP_LOAD;
			end
			gatq_pkg::ACT_BEGIN: begin
				push_item.op = gatq_pkg::OP_BEGIN;
			end
			gatq_pkg::ACT_RENDER: begin
				if (req.char_code == gatq_pkg::CODE_NEWLINE) begin
					push_item.op = gatq_pkg::OP_NEWLINE;
				end else begin
					push_item.op = gatq_pkg::OP_GLYPH;
					keep         = in_table && !req.char_code[7];
				end
			end
			default: begin
				push_item.op = gatq_pkg::OP_CLEAR;
			end
		endcase
	end

endmodule

/* src/gatq_fifo.sv */
// ----------------------------------------------------------------------------
// gatq_fifo: operation queue
// Short first-in first-out queue between intake and execution.
// ----------------------------------------------------------------------------
module gatq_fifo #(
	parameter int DEPTH = gatq_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gatq_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output gatq_pkg::item_t pop_item,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gatq_pkg::item_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue pushed when full or popped when empty");

endmodule

/* src/gatq_back.sv */
// ----------------------------------------------------------------------------
// gatq_back: operation execution
// Holds the glyph table, packing state, pen and configuration; packs
// loads, sequences quad vertices and drives the result register.
// ----------------------------------------------------------------------------
module gatq_back #(
	parameter int TABLE_DEPTH = gatq_pkg::GLYPH_TABLE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	gatq_cfg_if.sink        cfg,
	gatq_out_if.source      rsp,
	input  logic            empty,
	input  gatq_pkg::item_t head,
	output logic            pop
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	gatq_pkg::state_t   state_q, state_n;
	gatq_pkg::item_t    cur_q;
	logic [12:0]        max_row_width_q;
	logic [9:0]         line_height_q;
	logic [9:0]         font_size_q;
	logic [12:0]        pack_x_q;
	logic [14:0]        pack_y_q;
	logic [7:0]         row_h_q;
	logic [12:0]        widest_q;
	logic signed [19:0] pen_x_q;
	logic signed [19:0] pen_y_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	gatq_pkg::glyph_t   tbl_q [TABLE_DEPTH];
	gatq_pkg::glyph_t   rd_q;
	logic               rd_vld_q;
	logic signed [19:0] left_q, right_q, top_q, bot_q;
	logic [12:0]        u0_q, u1_q;
	logic [14:0]        v0_q, v1_q;
	logic [2:0]         vtx_q;
	logic               out_valid_q;
	gatq_pkg::res_t     res_q;

	logic [IDX_W-1:0]   idx;
	logic               out_free;
	logic               emit;
	logic               mem_we;
	logic               exec_load;
	logic [13:0]        load_end;
	logic               close_row;
	logic [12:0]        place_u;
	logic [14:0]        place_v;
	logic [12:0]        widest_n;
	logic [7:0]         row_h_base;
	logic [13:0]        pack_x_sum;
	logic [12:0]        atlas_w;
	logic [14:0]        atlas_h;
	gatq_pkg::glyph_t   glyph;
	logic               visible;
	logic signed [21:0] left_w, right_w, top_w, bot_w;
	logic [9:0]         extra;
	logic signed [11:0] start_y;
	gatq_pkg::res_t     res_n;

	assign idx       = cur_q.code[IDX_W-1:0];
	assign exec_load = state_q == gatq_pkg::ST_EXEC && cur_q.op == gatq_pkg::OP_LOAD;

	// packing
	assign load_end   = {1'b0, pack_x_q} + 14'(cur_q.bw) + 14'd1;
	assign close_row  = load_end >= {1'b0, max_row_width_q};
	assign place_u    = close_row ? '0 : pack_x_q;
	assign place_v    = close_row ? gatq_pkg::sat_v({1'b0, pack_y_q} + 16'(row_h_q)) : pack_y_q;
	assign row_h_base = close_row ? '0 : row_h_q;
	assign widest_n   = (close_row && pack_x_q > widest_q) ? pack_x_q : widest_q;
	assign pack_x_sum = {1'b0, place_u} + 14'(cur_q.bw) + 14'd1;

	assign atlas_w = (widest_q > pack_x_q) ? widest_q : pack_x_q;
	assign atlas_h = gatq_pkg::sat_v({1'b0, pack_y_q} + 16'(row_h_q));

	// quad geometry
	assign glyph   = rd_vld_q ? rd_q : '0;
	assign visible = glyph.bw != '0 && glyph.bh != '0;
	assign left_w  = 22'(pen_x_q) + (22'(glyph.bl) <<< 1);
	assign right_w = left_w + 22'({glyph.bw, 1'b0});
	assign top_w   = 22'(pen_y_q) + (22'(glyph.bt) <<< 1);
	assign bot_w   = top_w - 22'({glyph.bh, 1'b0});

	assign extra   = (line_height_q > font_size_q) ? line_height_q - font_size_q : '0;
	assign start_y = 12'({2'b00, extra}) - 12'({1'b0, line_height_q, 1'b0});

	assign cfg.ready = 1'b1;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			gatq_pkg::ST_IDLE: begin
				if (!empty) begin
					state_n = gatq_pkg::ST_EXEC;
				end
			end
			gatq_pkg::ST_EXEC: begin
				if (cur_q.op == gatq_pkg::OP_LOAD) begin
					state_n = gatq_pkg::ST_STATUS;
				end else if (cur_q.op == gatq_pkg::OP_GLYPH) begin
					state_n = gatq_pkg::ST_CALC;
				end else begin
					state_n = gatq_pkg::ST_IDLE;
				end
			end
			gatq_pkg::ST_STATUS: begin
				if (out_free) begin
					state_n = gatq_pkg::ST_IDLE;
				end
			end
			gatq_pkg::ST_CALC: begin
				state_n = visible ? gatq_pkg::ST_EMIT : gatq_pkg::ST_IDLE;
			end
			gatq_pkg::ST_EMIT: begin
				if (out_free && vtx_q == gatq_pkg::VTX_LAST) begin
					state_n = gatq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = gatq_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		out_free = !out_valid_q || rsp.ready;
		pop      = state_q == gatq_pkg::ST_IDLE && !empty;
		emit     = (state_q == gatq_pkg::ST_STATUS || state_q == gatq_pkg::ST_EMIT) && out_free;
		mem_we   = exec_load && cur_q.store;
	end

	// result assembly
	always_comb begin
		res_n             = '0;
		res_n.used_width  = atlas_w;
		res_n.used_height = atlas_h;
		if (state_q == gatq_pkg::ST_EMIT) begin
			res_n.is_vertex = 1'b1;
			res_n.last      = vtx_q == gatq_pkg::VTX_LAST;
			res_n.vertex_x  = gatq_pkg::VTX_RIGHT[vtx_q] ? right_q : left_q;
			res_n.vertex_y  = gatq_pkg::VTX_BOTTOM[vtx_q] ? bot_q : top_q;
			res_n.tex_u     = gatq_pkg::VTX_RIGHT[vtx_q] ? u1_q : u0_q;
			res_n.tex_v     = gatq_pkg::VTX_BOTTOM[vtx_q] ? v1_q : v0_q;
		end else begin
			res_n.last  = 1'b1;
			res_n.tex_u = u0_q;
			res_n.tex_v = v0_q;
		end
	end

	// glyph table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_q[idx] <= '{ax: cur_q.ax, ay: cur_q.ay, bw: cur_q.bw, bh: cur_q.bh,
				bl: cur_q.bl, bt: cur_q.bt, u: place_u, v: place_v};
		end
		rd_q <= tbl_q[idx];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (exec_load) begin
			u0_q <= place_u;
			v0_q <= place_v;
		end
		if (state_q == gatq_pkg::ST_CALC) begin
			left_q  <= gatq_pkg::sat_pos(left_w);
			right_q <= gatq_pkg::sat_pos(right_w);
			top_q   <= gatq_pkg::sat_pos(top_w);
			bot_q   <= gatq_pkg::sat_pos(bot_w);
			u0_q    <= glyph.u;
			v0_q    <= glyph.v;
			u1_q    <= gatq_pkg::sat_u({1'b0, glyph.u} + 14'(glyph.bw));
			v1_q    <= gatq_pkg::sat_v({1'b0, glyph.v} + 16'(glyph.bh));
		end
		if (emit) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= gatq_pkg::ST_IDLE;
			max_row_width_q <= gatq_pkg::MAX_ROW_WIDTH_RST;
			line_height_q   <= gatq_pkg::LINE_HEIGHT_RST;
			font_size_q     <= gatq_pkg::FONT_SIZE_RST;
			pack_x_q        <= '0;
			pack_y_q        <= '0;
			row_h_q         <= '0;
			widest_q        <= '0;
			pen_x_q         <= '0;
			pen_y_q         <= '0;
			valid_q         <= '0;
			rd_vld_q        <= 1'b0;
			vtx_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q  <= state_n;
			rd_vld_q <= valid_q[idx];
			if (cfg.valid) begin
				unique case (gatq_pkg::reg_idx_t'(cfg.index))
					gatq_pkg::REG_MAX_ROW_WIDTH: max_row_width_q <= cfg.data;
					gatq_pkg::REG_LINE_HEIGHT:   line_height_q   <= cfg.data[9:0];
					gatq_pkg::REG_FONT_SIZE:     font_size_q     <= cfg.data[9:0];
					default: begin
					end
				endcase
			end
			if (state_q == gatq_pkg::ST_EXEC) begin
				unique case (cur_q.op)
					gatq_pkg::OP_CLEAR: begin
						valid_q  <= '0;
						pack_x_q <= '0;
						pack_y_q <= '0;
						row_h_q  <= '0;
						widest_q <= '0;
					end
					gatq_pkg::OP_LOAD: begin
						widest_q <= widest_n;
						pack_y_q <= place_v;
						pack_x_q <= gatq_pkg::sat_u(pack_x_sum);
						row_h_q  <= (cur_q.bh > row_h_base) ? cur_q.bh : row_h_base;
						if (cur_q.store) begin
							valid_q[idx] <= 1'b1;
						end
					end
					gatq_pkg::OP_BEGIN: begin
						pen_x_q <= '0;
						pen_y_q <= 20'(start_y);
					end
					gatq_pkg::OP_NEWLINE: begin
						pen_x_q <= '0;
						pen_y_q <= gatq_pkg::sat_pos(22'(pen_y_q) - 22'({line_height_q, 1'b0}));
					end
					default: begin
					end
				endcase
			end
			if (state_q == gatq_pkg::ST_CALC) begin
				pen_x_q <= gatq_pkg::sat_pos(22'(pen_x_q) + (22'(glyph.ax) <<< 1));
				pen_y_q <= gatq_pkg::sat_pos(22'(pen_y_q) + (22'(glyph.ay) <<< 1));
				vtx_q   <= '0;
			end
			if (emit && state_q == gatq_pkg::ST_EMIT) begin
				vtx_q <= vtx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.is_vertex   = res_q.is_vertex;
	assign rsp.last        = res_q.last;
	assign rsp.vertex_x    = res_q.vertex_x;
	assign rsp.vertex_y    = res_q.vertex_y;
	assign rsp.tex_u       = res_q.tex_u;
	assign rsp.tex_v       = res_q.tex_v;
	assign rsp.used_width  = res_q.used_width;
	assign rsp.used_height = res_q.used_height;

	a_vtx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gatq_pkg::ST_EMIT |-> vtx_q <= gatq_pkg::VTX_LAST)
		else $error("vertex counter beyond quad");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.is_vertex |-> res_q.last)
		else $error("status item without last");

	a_clear_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gatq_pkg::ST_EXEC && cur_q.op == gatq_pkg::OP_CLEAR |=> valid_q == '0)
		else $error("glyph table not empty after clear");

endmodule

/* src/glyph_atlas_packer_and_text_quads_unit.sv */
// Glyph atlas packer and text quad unit. Items enter through a two-entry queue
// and run one at a time in the execution unit: clear, begin text and newline
// take only the execute step, renders of empty or unloaded glyphs also run
// quad setup, renders of codes 128 and above or beyond the table are dropped
// at intake, a glyph load gives one status item, and a visible character runs
// table read, quad setup and six vertex items, one per cycle while the result
// side takes them. The glyph table is one memory with a registered read port;
// entry valid bits clear at reset and on clear, so no sweep is needed.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
// glyph_atlas_packer_and_text_quads_unit: top level
// Shelf-packed glyph atlas with text quad vertex generation.
// ----------------------------------------------------------------------------
module glyph_atlas_packer_and_text_quads_unit #(
	parameter int GLYPH_TABLE_DEPTH = gatq_pkg::GLYPH_TABLE_DEPTH,
	parameter int QUEUE_DEPTH       = gatq_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	gatq_in_if.sink    req,
	gatq_out_if.source rsp,
	gatq_cfg_if.sink   cfg
);

	logic            push;
	logic            full;
	logic            pop;
	logic            empty;
	gatq_pkg::item_t push_item;
	gatq_pkg::item_t head;

	gatq_front #(
		.TABLE_DEPTH(GLYPH_TABLE_DEPTH)
	) u_front (
		.req      (req),
		.full     (full),
		.push     (push),
		.push_item(push_item)
	);

	gatq_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.pop_item (head),
		.empty    (empty)
	);

	gatq_back #(
		.TABLE_DEPTH(GLYPH_TABLE_DEPTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.rsp   (rsp),
		.empty (empty),
		.head  (head),
		.pop   (pop)
	);

endmodule
